/* hdl/eau_pkg.sv */
// ----------------------------------------------------------------------------
// Elementwise activation unit package
// Shared word types, function codes, fixed-point constants and helpers.
// ----------------------------------------------------------------------------
package eau_pkg;

  localparam int SEGMENTS_DEFAULT = 64;

  localparam logic signed [31:0] LEAK_RESET = 32'sd655;
  localparam logic signed [31:0] GELU_LIM   = 32'sd1048576;
  localparam logic signed [31:0] C1_Q24     = 32'sd13386282;
  localparam logic signed [31:0] C2_Q24     = 32'sd750193;
  localparam logic signed [31:0] C3_Q24     = 32'sd2250580;

  typedef enum logic [3:0] {
    FN_RELU_FWD  = 4'd0,
    FN_RELU_BWD  = 4'd1,
    FN_LEAKY_FWD = 4'd2,
    FN_LEAKY_BWD = 4'd3,
    FN_SIG_FWD   = 4'd4,
    FN_SIG_BWD   = 4'd5,
    FN_TANH_FWD  = 4'd6,
    FN_TANH_BWD  = 4'd7,
    FN_GELU_FWD  = 4'd8,
    FN_GELU_BWD  = 4'd9
  } func_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] value;
    logic signed [31:0] grad;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               flag;
  } sat_t;

  // Hand-off from the front stages to the back stages.
  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] x;
    logic signed [31:0] g;
    logic signed [21:0] xc;
    logic signed [22:0] dinner;
    logic signed [31:0] early;
    logic               eflag;
    logic signed [31:0] targ;
  } mid_t;

  // Shift right by s with rounding half up.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] p, input int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.val  = 32'sh7fffffff;
      r.flag = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val  = 32'sh80000000;
      r.flag = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.flag = 1'b0;
    end
    return r;
  endfunction

  // Restoring division, used only while building the knot table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Knot k of the tanh table, tanh(8k/seg) in Q16.16.
  function automatic logic signed [17:0] knot_val(input int seg, input int k);
    logic signed [63:0] one;
    logic signed [63:0] d;
    logic signed [63:0] term;
    logic signed [63:0] e;
    logic signed [63:0] p;
    logic signed [63:0] qm;
    logic               done;
    one  = 64'sd1 <<< 30;
    d    = $signed(udiv64(64'd1 << 34, 64'(seg)));
    term = one;
    e    = one;
    p    = one;
    done = 1'b0;
    for (int n = 1; n <= 40; n++) begin
      if (!done) begin
        term = rnd_shr(term * (-d), 30);
        qm   = $signed(udiv64($unsigned((term < 0) ? -term : term), 64'(n)));
        term = (term < 0) ? -qm : qm;
        if (term == 0) begin
          done = 1'b1;
        end else begin
          e = e + term;
        end
      end
    end
    for (int j = 1; j <= k; j++) begin
      p = rnd_shr(p * e, 30);
    end
    return 18'(udiv64($unsigned(((one - p) <<< 16) + ((one + p) >>> 1)),
                      $unsigned(one + p)));
  endfunction

endpackage

/* hdl/eau_front.sv */
// ----------------------------------------------------------------------------
// Activation unit front stages
// Four stages: simple activations, derivative products and the GELU inner
// polynomial, ending in the tanh argument.
// ----------------------------------------------------------------------------
module eau_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  eau_pkg::in_word_t  in_word,
  input  logic signed [31:0] alpha,
  output logic               fr_valid,
  output eau_pkg::mid_t      fr_word
);
  import eau_pkg::*;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] x;
    logic signed [31:0] g;
    logic signed [21:0] xc;
    logic signed [25:0] x2;
    logic signed [31:0] early;
    logic               eflag;
    logic signed [31:0] d;
    logic               dflag;
  } st1_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] x;
    logic signed [31:0] g;
    logic signed [21:0] xc;
    logic signed [29:0] x3;
    logic signed [22:0] da;
    logic signed [31:0] early;
    logic               eflag;
  } st2_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] x;
    logic signed [31:0] g;
    logic signed [21:0] xc;
    logic signed [24:0] ia;
    logic signed [22:0] dinner;
    logic signed [31:0] early;
    logic               eflag;
  } st3_t;

  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  mid_t s4_r, s4_nxt;
  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [32:0] bw_op;
  logic signed [63:0] bw_p;
  logic signed [63:0] bw_q;
  logic signed [63:0] lk_p;
  sat_t               lk_s;
  sat_t               sg_s;
  sat_t               th_s;
  sat_t               gd_s;
  logic               xpos;
  logic signed [31:0] inner;

  always_comb begin
    s1_nxt.func  = in_word.func;
    s1_nxt.x     = in_word.value;
    s1_nxt.g     = in_word.grad;
    xpos         = (in_word.value > 32'sd0);
    if (in_word.value > GELU_LIM) begin
      s1_nxt.xc = 22'(GELU_LIM);
    end else if (in_word.value < -GELU_LIM) begin
      s1_nxt.xc = 22'(-GELU_LIM);
    end else begin
      s1_nxt.xc = in_word.value[21:0];
    end
    s1_nxt.x2 = 26'(rnd_shr(64'(s1_nxt.xc) * 64'(s1_nxt.xc), 16));

    bw_op = (in_word.func == FN_SIG_BWD) ? (33'sd65536 - 33'(in_word.value))
                                          : 33'(in_word.value);
    bw_p  = 64'(in_word.value) * 64'(bw_op);
    bw_q  = rnd_shr(bw_p, 16);
    sg_s  = sat32(bw_q);
    th_s  = sat32(64'sd65536 - bw_q);
    if (in_word.func == FN_SIG_BWD) begin
      s1_nxt.d     = sg_s.val;
      s1_nxt.dflag = sg_s.flag;
    end else begin
      s1_nxt.d     = th_s.val;
      s1_nxt.dflag = th_s.flag;
    end

    lk_p = 64'(alpha) * 64'((in_word.func == FN_LEAKY_FWD) ? in_word.value : in_word.grad);
    lk_s = sat32(rnd_shr(lk_p, 16));

    s1_nxt.early = '0;
    s1_nxt.eflag = 1'b0;
    case (in_word.func)
      FN_RELU_FWD: begin
        s1_nxt.early = xpos ? in_word.value : 32'sd0;
      end
      FN_RELU_BWD: begin
        s1_nxt.early = xpos ? in_word.grad : 32'sd0;
      end
      FN_LEAKY_FWD: begin
        s1_nxt.early = xpos ? in_word.value : lk_s.val;
        s1_nxt.eflag = !xpos && lk_s.flag;
      end
      FN_LEAKY_BWD: begin
        s1_nxt.early = xpos ? in_word.grad : lk_s.val;
        s1_nxt.eflag = !xpos && lk_s.flag;
      end
      default: begin
        s1_nxt.early = '0;
        s1_nxt.eflag = 1'b0;
      end
    endcase
  end

  always_comb begin
    s2_nxt.func  = s1_r.func;
    s2_nxt.x     = s1_r.x;
    s2_nxt.g     = s1_r.g;
    s2_nxt.xc    = s1_r.xc;
    s2_nxt.x3    = 30'(rnd_shr(64'(s1_r.x2) * 64'(s1_r.xc), 16));
    s2_nxt.da    = 23'(rnd_shr(64'(s1_r.x2) * 64'(C3_Q24), 24));
    gd_s         = sat32(rnd_shr(64'(s1_r.g) * 64'(s1_r.d), 16));
    s2_nxt.early = s1_r.early;
    s2_nxt.eflag = s1_r.eflag;
    if (s1_r.func == FN_SIG_BWD || s1_r.func == FN_TANH_BWD) begin
      s2_nxt.early = gd_s.val;
      s2_nxt.eflag = s1_r.dflag | gd_s.flag;
    end
  end

  always_comb begin
    s3_nxt.func   = s2_r.func;
    s3_nxt.x      = s2_r.x;
    s3_nxt.g      = s2_r.g;
    s3_nxt.xc     = s2_r.xc;
    s3_nxt.ia     = 25'(64'(s2_r.xc) + rnd_shr(64'(s2_r.x3) * 64'(C2_Q24), 24));
    s3_nxt.dinner = 23'(rnd_shr((64'sd65536 + 64'(s2_r.da)) * 64'(C1_Q24), 24));
    s3_nxt.early  = s2_r.early;
    s3_nxt.eflag  = s2_r.eflag;
  end

  always_comb begin
    inner         = 32'(rnd_shr(64'(s3_r.ia) * 64'(C1_Q24), 24));
    s4_nxt.func   = s3_r.func;
    s4_nxt.x      = s3_r.x;
    s4_nxt.g      = s3_r.g;
    s4_nxt.xc     = s3_r.xc;
    s4_nxt.dinner = s3_r.dinner;
    s4_nxt.early  = s3_r.early;
    s4_nxt.eflag  = s3_r.eflag;
    if (s3_r.func == FN_SIG_FWD) begin
      s4_nxt.targ = s3_r.x >>> 1;
    end else if (s3_r.func == FN_TANH_FWD) begin
      s4_nxt.targ = s3_r.x;
    end else begin
      s4_nxt.targ = inner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign fr_valid = v4_r;
  assign fr_word  = s4_r;

endmodule

/* hdl/eau_tanh.sv */
// ----------------------------------------------------------------------------
// Activation unit tanh
// Two-stage piecewise-linear tanh: knot lookup, then interpolation and sign.
// ----------------------------------------------------------------------------
module eau_tanh #(
  parameter int TABLE_SEGMENTS = eau_pkg::SEGMENTS_DEFAULT
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] arg,
  output logic signed [17:0] t
);
  import eau_pkg::*;

  localparam int IW = $clog2(TABLE_SEGMENTS + 1);
  localparam int PW = 19 + IW;

  logic signed [17:0] knot_rom [TABLE_SEGMENTS + 1];

  for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_knot
    localparam logic signed [17:0] KV = knot_val(TABLE_SEGMENTS, k);
    assign knot_rom[k] = KV;
  end

  logic [32:0]        a;
  logic [PW-1:0]      p;
  logic [IW-1:0]      idx;
  logic signed [17:0] k0_r, k0_nxt;
  logic signed [17:0] k1_r, k1_nxt;
  logic [18:0]        f_r, f_nxt;
  logic               neg_r, neg_nxt;
  logic               big_r, big_nxt;
  logic signed [18:0] diff;
  logic signed [39:0] prod;
  logic signed [18:0] y;
  logic signed [17:0] t_r, t_nxt;

  always_comb begin
    neg_nxt = arg[31];
    a       = neg_nxt ? (33'd0 - {arg[31], arg}) : {1'b0, arg};
    big_nxt = (a >= 33'd524288);
    p       = PW'(a[18:0]) * PW'(TABLE_SEGMENTS);
    idx     = p[PW-1:19];
    f_nxt   = p[18:0];
    k0_nxt  = knot_rom[idx];
    k1_nxt  = knot_rom[idx + IW'(1)];
  end

  always_comb begin
    diff = 19'(k1_r) - 19'(k0_r);
    prod = 40'(diff) * $signed({21'd0, f_r});
    y    = 19'(k0_r) + 19'((prod + 40'sd262144) >>> 19);
    if (big_r) begin
      y = 19'sd65536;
    end
    t_nxt = neg_r ? 18'(-y) : 18'(y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k0_r  <= k0_nxt;
      k1_r  <= k1_nxt;
      f_r   <= f_nxt;
      neg_r <= neg_nxt;
      big_r <= big_nxt;
      t_r   <= t_nxt;
    end
  end

  assign t = t_r;

endmodule

/* hdl/eau_back.sv */
// ----------------------------------------------------------------------------
// Activation unit back stages
// Four stages: tanh-based results, the GELU derivative chain and the output
// register.
// ----------------------------------------------------------------------------
module eau_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                mid_valid,
  input  eau_pkg::mid_t       mid_word,
  input  logic signed [17:0]  t,
  output logic                out_valid,
  output eau_pkg::out_word_t  out_word
);
  import eau_pkg::*;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] g;
    logic signed [21:0] xc;
    logic signed [22:0] dinner;
    logic signed [17:0] sech2;
    logic signed [17:0] half;
    logic signed [31:0] early;
    logic               eflag;
  } st7_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] g;
    logic signed [22:0] dinner;
    logic signed [21:0] xs;
    logic signed [17:0] half;
    logic signed [31:0] early;
    logic               eflag;
  } st8_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] g;
    logic signed [26:0] deriv;
    logic signed [31:0] early;
    logic               eflag;
  } st9_t;

  st7_t      s7_r, s7_nxt;
  st8_t      s8_r, s8_nxt;
  st9_t      s9_r, s9_nxt;
  out_word_t o_r, o_nxt;
  logic      v7_r, v8_r, v9_r, v10_r;

  logic signed [18:0] opt;
  sat_t               gf_s;
  sat_t               gr_s;

  always_comb begin
    opt           = 19'(t) + 19'sd65536;
    gf_s          = sat32(rnd_shr(64'(mid_word.x) * 64'(opt), 17));
    s7_nxt.func   = mid_word.func;
    s7_nxt.g      = mid_word.g;
    s7_nxt.xc     = mid_word.xc;
    s7_nxt.dinner = mid_word.dinner;
    s7_nxt.sech2  = 18'(64'sd65536 - rnd_shr(64'(t) * 64'(t), 16));
    s7_nxt.half   = 18'((opt + 19'sd1) >>> 1);
    s7_nxt.early  = mid_word.early;
    s7_nxt.eflag  = mid_word.eflag;
    case (mid_word.func)
      FN_SIG_FWD: begin
        s7_nxt.early = 32'(s7_nxt.half);
      end
      FN_TANH_FWD: begin
        s7_nxt.early = 32'(t);
      end
      FN_GELU_FWD: begin
        s7_nxt.early = gf_s.val;
        s7_nxt.eflag = gf_s.flag;
      end
      default: begin
        s7_nxt.early = mid_word.early;
      end
    endcase
  end

  always_comb begin
    s8_nxt.func   = s7_r.func;
    s8_nxt.g      = s7_r.g;
    s8_nxt.dinner = s7_r.dinner;
    s8_nxt.xs     = 22'(rnd_shr(64'(s7_r.xc) * 64'(s7_r.sech2), 16));
    s8_nxt.half   = s7_r.half;
    s8_nxt.early  = s7_r.early;
    s8_nxt.eflag  = s7_r.eflag;
  end

  always_comb begin
    s9_nxt.func  = s8_r.func;
    s9_nxt.g     = s8_r.g;
    s9_nxt.deriv = 27'(64'(s8_r.half) + rnd_shr(64'(s8_r.xs) * 64'(s8_r.dinner), 17));
    s9_nxt.early = s8_r.early;
    s9_nxt.eflag = s8_r.eflag;
  end

  always_comb begin
    gr_s = sat32(rnd_shr(64'(s9_r.g) * 64'(s9_r.deriv), 16));
    if (s9_r.func == FN_GELU_BWD) begin
      o_nxt.result    = gr_s.val;
      o_nxt.saturated = gr_s.flag;
    end else begin
      o_nxt.result    = s9_r.early;
      o_nxt.saturated = s9_r.eflag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v7_r  <= mid_valid;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r <= s7_nxt;
      s8_r <= s8_nxt;
      s9_r <= s9_nxt;
      o_r  <= o_nxt;
    end
  end

  assign out_valid = v10_r;
  assign out_word  = o_r;

endmodule

/* hdl/elementwise_activation_unit.sv */
// ----------------------------------------------------------------------------
// Elementwise activation unit
// Q16.16 forward and backward ReLU, leaky ReLU, sigmoid, tanh and GELU.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | func, value, grad
//  out_    | output    | out_valid/out_stall| result, saturated
//  cfg_    | input     | cfg_valid/cfg_ready| leak slope, Q16.16
//
// One word is taken every cycle unless the output is stalled. Each result
// passes the ten-stage multiplier pipeline, with the tanh table in stages
// five and six. Reset clears all valid bits and loads the leak slope. A
// stalled output word holds the whole pipeline and raises in_stall.
module elementwise_activation_unit #(
  parameter int TABLE_SEGMENTS = eau_pkg::SEGMENTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  eau_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output eau_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import eau_pkg::*;

  logic signed [31:0] leak_r, leak_nxt;
  logic               en;
  logic               fr_valid;
  mid_t               fr_word;
  logic signed [17:0] t;
  mid_t               m1_r, m2_r;
  logic               mv1_r, mv2_r;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign leak_nxt  = (cfg_valid && cfg_ready) ? $signed(cfg_data) : leak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_r <= LEAK_RESET;
    end else begin
      leak_r <= leak_nxt;
    end
  end

  eau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_word  (in_word),
    .alpha    (leak_r),
    .fr_valid (fr_valid),
    .fr_word  (fr_word)
  );

  eau_tanh #(
    .TABLE_SEGMENTS (TABLE_SEGMENTS)
  ) u_tanh (
    .clk (clk),
    .en  (en),
    .arg (fr_word.targ),
    .t   (t)
  );

  // Carry the rest of the word alongside the two tanh stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv1_r <= 1'b0;
      mv2_r <= 1'b0;
    end else if (en) begin
      mv1_r <= fr_valid;
      mv2_r <= mv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= fr_word;
      m2_r <= m1_r;
    end
  end

  eau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .mid_valid (mv2_r),
    .mid_word  (m2_r),
    .t         (t),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef SYNTH
  a_leak_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_valid && cfg_ready) |=> $stable(leak_r))
    else $error("leak slope changed without a write");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(mv1_r) && $stable(mv2_r) && $stable(m2_r)))
    else $error("pipeline moved during a stall");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (!out_valid && !mv1_r && !mv2_r))
    else $error("pipeline not empty after reset");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Elementwise activation unit testbench
// Drives directed and random Q16.16 elements through every activation form,
// predicts each result word in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import eau_pkg::*;

  localparam int SEGS = 64;
  localparam int LATENCY = 10;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] value;
    logic signed [31:0] grad;
    logic               known;
    logic signed [31:0] result;
    logic               saturated;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;

  elementwise_activation_unit #(.TABLE_SEGMENTS(SEGS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  longint knots [0:SEGS];
  logic signed [31:0] slope;
  out_word_t pending_results [$];
  int mismatches;
  int idle_cycles;
  bit timed_out;
  bit hold_off_req;
  bit rx_busy;
  int rx_wait;

  initial begin
    clk = 1'b0;
  end
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rmul(longint a, longint b, int s);
    return (a * b + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic build_knots();
    longint one, d, term, e, p;
    one = 64'sd1 <<< 30;
    d = (64'sd1 <<< 34) / SEGS;
    term = one;
    e = one;
    p = one;
    for (int n = 1; n <= 40; n++) begin
      term = rmul(term, -d, 30) / n;
      if (term == 0) break;
      e += term;
    end
    for (int k = 0; k <= SEGS; k++) begin
      if (k > 0) p = rmul(p, e, 30);
      knots[k] = (((one - p) <<< 16) + (one + p) / 2) / (one + p);
    end
  endtask

  function automatic longint tanh_pwl(longint x);
    longint a, y, p, i, f;
    a = (x < 0) ? -x : x;
    if (a >= (64'sd8 <<< 16)) begin
      y = 65536;
    end else begin
      p = a * SEGS;
      i = p >>> 19;
      f = p & ((64'sd1 <<< 19) - 1);
      y = knots[i] + (((knots[i + 1] - knots[i]) * f + (64'sd1 <<< 18)) >>> 19);
    end
    return (x < 0) ? -y : y;
  endfunction

  function automatic out_word_t activation(logic [3:0] func, logic signed [31:0] value,
                                           logic signed [31:0] grad);
    longint x, g, al, r, d, t, xc, x2, x3, inner, sech2, dinner, deriv;
    bit flag;
    out_word_t o;
    x = value;
    g = grad;
    al = slope;
    flag = 1'b0;
    r = 0;
    case (func)
      FN_RELU_FWD: r = (x > 0) ? x : 0;
      FN_RELU_BWD: r = (x > 0) ? g : 0;
      FN_LEAKY_FWD: r = (x > 0) ? x : clip32(rmul(al, x, 16), flag);
      FN_LEAKY_BWD: r = (x > 0) ? g : clip32(rmul(g, al, 16), flag);
      FN_SIG_FWD: begin
        t = tanh_pwl(asr64(x, 1));
        r = asr64(65536 + t + 1, 1);
      end
      FN_SIG_BWD: begin
        d = clip32(rmul(x, 65536 - x, 16), flag);
        r = clip32(rmul(g, d, 16), flag);
      end
      FN_TANH_FWD: r = tanh_pwl(x);
      FN_TANH_BWD: begin
        d = clip32(65536 - rmul(x, x, 16), flag);
        r = clip32(rmul(g, d, 16), flag);
      end
      FN_GELU_FWD, FN_GELU_BWD: begin
        xc = (x > 1048576) ? 1048576 : ((x < -1048576) ? -1048576 : x);
        x2 = rmul(xc, xc, 16);
        x3 = rmul(x2, xc, 16);
        inner = rmul(xc + rmul(x3, C2_Q24, 24), C1_Q24, 24);
        t = tanh_pwl(inner);
        if (func == FN_GELU_FWD) begin
          r = clip32(rmul(x, 65536 + t, 17), flag);
        end else begin
          sech2 = 65536 - rmul(t, t, 16);
          dinner = rmul(65536 + rmul(x2, C3_Q24, 24), C1_Q24, 24);
          deriv = asr64(65536 + t + 1, 1) + rmul(rmul(xc, sech2, 16), dinner, 17);
          r = clip32(rmul(g, deriv, 16), flag);
        end
      end
      default: r = 0;
    endcase
    o.result = r[31:0];
    o.saturated = flag;
    return o;
  endfunction

  task automatic write_slope(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slope = v;
  endtask

  task automatic send_word(logic [3:0] func, logic signed [31:0] value,
                           logic signed [31:0] grad);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word.func <= func;
    in_word.value <= value;
    in_word.grad <= grad;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(activation(func, value, grad));
  endtask

  task automatic send_burst(logic [3:0] func, logic signed [31:0] value,
                            logic signed [31:0] grad);
    in_valid <= 1'b1;
    in_word.func <= func;
    in_word.value <= value;
    in_word.grad <= grad;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(activation(func, value, grad));
  endtask

  task automatic drain();
    while (pending_results.size() != 0 && !timed_out) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1048575)) - 32'sd524288;
      2: return $signed($urandom_range(0, 262143)) - 32'sd131072;
      3: return $signed($urandom_range(0, 4194303)) - 32'sd2097152;
      4: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 131071)) - 32'sd65536;
    endcase
  endfunction

  // Receiver side: a random wait per word, plus one long hold-off on request.
  always @(posedge clk) begin
    int wait_n;
    if (!rst_n) begin
      wait_n = 0;
    end else if (out_valid && !out_stall) begin
      wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    end else if (rx_wait > 0) begin
      wait_n = rx_wait - 1;
    end else begin
      wait_n = 0;
    end
    rx_wait <= wait_n;
    out_stall <= rst_n && (rx_busy || (wait_n > 0));
  end

  initial begin
    rx_busy = 1'b0;
    wait (hold_off_req);
    @(posedge clk);
    rx_busy <= 1'b1;
    repeat (120) @(posedge clk);
    rx_busy <= 1'b0;
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word: result %0d", out_word.result);
      end else begin
        exp_w = pending_results.pop_front();
        if (out_word.result !== exp_w.result || out_word.saturated !== exp_w.saturated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %0d/%0b actual %0d/%0b", exp_w.result,
                     exp_w.saturated, out_word.result, out_word.saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  stim_row_t directed [] = '{
    '{FN_RELU_FWD, 32'sh7fffffff, 32'sd0, 1'b1, 32'sh7fffffff, 1'b0},
    '{FN_RELU_FWD, 32'sh80000000, 32'sd0, 1'b1, 32'sd0, 1'b0},
    '{FN_RELU_BWD, 32'sd1, 32'sh80000000, 1'b1, 32'sh80000000, 1'b0},
    '{FN_RELU_BWD, 32'sd0, 32'sh7fffffff, 1'b1, 32'sd0, 1'b0},
    '{FN_LEAKY_FWD, 32'sh80000000, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{FN_LEAKY_FWD, 32'sd65536, 32'sd0, 1'b1, 32'sd65536, 1'b0},
    '{FN_LEAKY_BWD, -32'sd65536, 32'sh7fffffff, 1'b0, 32'sd0, 1'b0},
    '{FN_LEAKY_BWD, 32'sd5, 32'sh80000000, 1'b1, 32'sh80000000, 1'b0},
    '{FN_SIG_FWD, 32'sd0, 32'sd0, 1'b1, 32'sd32768, 1'b0},
    '{FN_SIG_FWD, 32'sh7fffffff, 32'sd0, 1'b1, 32'sd65536, 1'b0},
    '{FN_SIG_FWD, 32'sh80000000, 32'sd0, 1'b1, 32'sd0, 1'b0},
    '{FN_SIG_BWD, 32'sh80000000, 32'sh7fffffff, 1'b0, 32'sd0, 1'b0},
    '{FN_SIG_BWD, 32'sd32768, 32'sd65536, 1'b0, 32'sd0, 1'b0},
    '{FN_TANH_FWD, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0},
    '{FN_TANH_FWD, 32'sd524288, 32'sd0, 1'b1, 32'sd65536, 1'b0},
    '{FN_TANH_FWD, -32'sd524287, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{FN_TANH_BWD, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sd0, 1'b0},
    '{FN_TANH_BWD, 32'sd0, 32'sh80000000, 1'b1, 32'sh80000000, 1'b0},
    '{FN_GELU_FWD, 32'sh7fffffff, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{FN_GELU_FWD, 32'sh80000000, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{FN_GELU_FWD, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0},
    '{FN_GELU_BWD, 32'sd1048577, 32'sh7fffffff, 1'b0, 32'sd0, 1'b0},
    '{FN_GELU_BWD, -32'sd70000, 32'sh80000000, 1'b0, 32'sd0, 1'b0},
    '{4'd10, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 32'sd0, 1'b0},
    '{4'd15, 32'sh80000000, 32'sh80000000, 1'b1, 32'sd0, 1'b0}
  };

  initial begin
    logic [31:0] slopes [5];
    out_word_t typed;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    slope = LEAK_RESET;
    build_knots();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].known) begin
        typed = activation(directed[i].func, directed[i].value, directed[i].grad);
        if (typed.result !== directed[i].result
            || typed.saturated !== directed[i].saturated) begin
          mismatches++;
          $display("Table row %0d disagrees with predictor", i);
        end
      end
      send_word(directed[i].func, directed[i].value, directed[i].grad);
    end
    in_valid <= 1'b0;
    drain();

    slopes = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffff0000, 32'h00008000};
    for (int ph = 0; ph < 5; ph++) begin
      write_slope(slopes[ph]);
      if (ph == 1) begin
        hold_off_req = 1'b1;
        for (int k = 0; k < 60; k++) begin
          send_burst(4'($urandom_range(0, 9)), rand_value(), $urandom);
        end
      end
      for (int k = 0; k < 320; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_burst(4'($urandom_range(0, 15)), rand_value(), rand_value());
        end else begin
          send_word(4'($urandom_range(0, 9)), rand_value(),
                    ($urandom_range(0, 3) == 0) ? $urandom : rand_value());
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/eau_pkg.sv
hdl/eau_front.sv
hdl/eau_tanh.sv
hdl/eau_back.sv
hdl/elementwise_activation_unit.sv
tb/tb_top.sv
